// ===== hdl/particle_wall_interaction_defines.svh =====
// Assertion macros shared by the particle wall interaction RTL.
`ifndef PARTICLE_WALL_INTERACTION_DEFINES_SVH
`define PARTICLE_WALL_INTERACTION_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PWI_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("particle wall interaction assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define PWI_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("particle wall interaction assertion failed");

`endif

// ===== hdl/pwi_pkg.sv =====
// Types and constants shared by the particle wall interaction pipeline.
package pwi_pkg;

    localparam int NUM_PATCHES  = 4;
    localparam int REG_COUNT    = NUM_PATCHES + 1;
    localparam int REG_IDX_W    = $clog2(REG_COUNT);
    localparam int PADDR_W      = REG_IDX_W + 3;
    localparam int DATA_W       = 64;
    localparam int CNT_W        = 3;
    localparam int ENTRY_W      = 50;
    localparam int SUM_W        = 64;
    localparam int ROOT_W       = SUM_W / 2;

    localparam int FRONT_STAGES = 5;
    localparam int SQRT_STAGES  = ROOT_W;
    localparam int DIV_STEPS    = 31;
    localparam int DIV_STAGES   = DIV_STEPS + 1;
    localparam int BACK_STAGES  = 7;
    localparam int LATENCY      = FRONT_STAGES + SQRT_STAGES + DIV_STAGES + BACK_STAGES;

    localparam logic [REG_IDX_W-1:0] REG_PATCH_COUNT = '0;

    typedef enum logic [1:0] {
        PT_ESCAPE  = 2'd0,
        PT_STICK   = 2'd1,
        PT_REBOUND = 2'd2,
        PT_INVALID = 2'd3
    } t_patch_type;

    typedef struct packed {
        logic [15:0] friction;
        logic [15:0] restitution;
        t_patch_type ptype;
        logic [15:0] id;
    } t_patch_entry;

    typedef struct packed {
        logic        [15:0] patch_id;
        logic signed [31:0] area_x;
        logic signed [31:0] area_y;
        logic signed [31:0] area_z;
        logic signed [31:0] vel_in_x;
        logic signed [31:0] vel_in_y;
        logic signed [31:0] vel_in_z;
    } t_in_item;

    typedef struct packed {
        logic               matched;
        logic               keep_particle;
        logic               still_active;
        logic               bad_type;
        logic signed [31:0] vel_out_x;
        logic signed [31:0] vel_out_y;
        logic signed [31:0] vel_out_z;
    } t_out_item;

    // Per-item decision and operands that ride alongside the arithmetic.
    typedef struct packed {
        logic             matched;
        logic             keep;
        logic             active;
        logic             bad;
        logic             zero_vel;
        logic             use_rebound;
        logic [15:0]      e;
        logic [15:0]      mu;
        logic [2:0][31:0] u;
    } t_side;

    typedef struct packed {
        logic [2:0][31:0] babs;
        logic [2:0]       bneg;
    } t_vec_mag;

endpackage

// ===== hdl/pwi_front.sv =====
// Front stages: patch lookup, area magnitude scaling and squared length.
module pwi_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    input  pwi_pkg::t_in_item                  i_item,
    input  logic [pwi_pkg::CNT_W-1:0]          i_patch_count,
    input  pwi_pkg::t_patch_entry              i_patch_entry [pwi_pkg::NUM_PATCHES],
    output logic                               o_valid,
    output logic [pwi_pkg::SUM_W-1:0]          o_sum,
    output pwi_pkg::t_vec_mag                  o_mag,
    output pwi_pkg::t_side                     o_side
);

    logic [pwi_pkg::FRONT_STAGES-1:0] r_v;

    pwi_pkg::t_side    n_side, r1_side, r2_side, r3_side, r4_side, r5_side;
    pwi_pkg::t_vec_mag n_mag, r1_mag, r2_mag, n_shift_mag, r3_mag, r4_mag, r5_mag;
    logic [31:0]       n_max, r2_max;
    logic [pwi_pkg::SUM_W-1:0] r4_sq [3];
    logic [pwi_pkg::SUM_W-1:0] r5_sum;

    always_comb begin
        logic                  hit;
        pwi_pkg::t_patch_entry ent;
        logic [2:0][31:0]      a;
        logic                  zero_area;
        hit = 1'b0;
        ent = '0;
        for (int i = pwi_pkg::NUM_PATCHES - 1; i >= 0; i--) begin
            if ((int'(i_patch_count) > i) && (i_patch_entry[i].id == i_item.patch_id)) begin
                hit = 1'b1;
                ent = i_patch_entry[i];
            end
        end
        a = {i_item.area_z, i_item.area_y, i_item.area_x};
        zero_area = (a[0] == '0) && (a[1] == '0) && (a[2] == '0);
        n_side.matched     = hit;
        n_side.keep        = 1'b1;
        n_side.active      = 1'b1;
        n_side.bad         = 1'b0;
        n_side.zero_vel    = 1'b0;
        n_side.use_rebound = 1'b0;
        n_side.e           = ent.restitution;
        n_side.mu          = ent.friction;
        n_side.u           = {i_item.vel_in_z, i_item.vel_in_y, i_item.vel_in_x};
        if (hit) begin
            case (ent.ptype)
                pwi_pkg::PT_ESCAPE: begin
                    n_side.keep     = 1'b0;
                    n_side.active   = 1'b0;
                    n_side.zero_vel = 1'b1;
                end
                pwi_pkg::PT_STICK: begin
                    n_side.active   = 1'b0;
                    n_side.zero_vel = 1'b1;
                end
                pwi_pkg::PT_REBOUND: begin
                    if (zero_area) begin
                        n_side.bad = 1'b1;
                    end else begin
                        n_side.use_rebound = 1'b1;
                    end
                end
                default: begin
                    n_side.bad = 1'b1;
                end
            endcase
        end
        for (int l = 0; l < 3; l++) begin
            n_mag.bneg[l] = a[l][31];
            n_mag.babs[l] = a[l][31] ? (~a[l] + 32'd1) : a[l];
        end
    end

    always_comb begin
        logic [31:0] m01;
        m01   = (r1_mag.babs[1] > r1_mag.babs[0]) ? r1_mag.babs[1] : r1_mag.babs[0];
        n_max = (r1_mag.babs[2] > m01) ? r1_mag.babs[2] : m01;
    end

    always_comb begin
        logic [4:0] hb;
        logic [4:0] k;
        hb = '0;
        for (int i = 0; i < 32; i++) begin
            if (r2_max[i]) begin
                hb = 5'(i);
            end
        end
        if (r2_max[31] || r2_max[30]) begin
            k = '0;
        end else begin
            k = 5'd30 - hb;
        end
        n_shift_mag.bneg = r2_mag.bneg;
        for (int l = 0; l < 3; l++) begin
            n_shift_mag.babs[l] = r2_mag.babs[l] << k;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[pwi_pkg::FRONT_STAGES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r1_side <= n_side;
        r1_mag  <= n_mag;
        r2_side <= r1_side;
        r2_mag  <= r1_mag;
        r2_max  <= n_max;
        r3_side <= r2_side;
        r3_mag  <= n_shift_mag;
        r4_side <= r3_side;
        r4_mag  <= r3_mag;
        for (int l = 0; l < 3; l++) begin
            r4_sq[l] <= r3_mag.babs[l] * r3_mag.babs[l];
        end
        r5_side <= r4_side;
        r5_mag  <= r4_mag;
        r5_sum  <= r4_sq[0] + r4_sq[1] + r4_sq[2];
    end

    assign o_valid = r_v[pwi_pkg::FRONT_STAGES-1];
    assign o_sum   = r5_sum;
    assign o_mag   = r5_mag;
    assign o_side  = r5_side;

endmodule

// ===== hdl/pwi_sqrt.sv =====
// Pipelined integer square root, one root bit per stage.
module pwi_sqrt (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [pwi_pkg::SUM_W-1:0]  i_sum,
    input  pwi_pkg::t_vec_mag          i_mag,
    input  pwi_pkg::t_side             i_side,
    output logic                       o_valid,
    output logic [pwi_pkg::ROOT_W-1:0] o_root,
    output pwi_pkg::t_vec_mag          o_mag,
    output pwi_pkg::t_side             o_side
);

    localparam int N     = pwi_pkg::SQRT_STAGES;
    localparam int REM_W = pwi_pkg::ROOT_W + 2;

    logic [N-1:0]                r_v;
    logic [REM_W-1:0]            r_rem  [N];
    logic [pwi_pkg::ROOT_W-1:0]  r_root [N];
    logic [pwi_pkg::SUM_W-1:0]   r_sum  [N];
    pwi_pkg::t_vec_mag           r_mag  [N];
    pwi_pkg::t_side              r_side [N];
    logic [REM_W-1:0]            c_rem  [N];
    logic [pwi_pkg::ROOT_W-1:0]  c_root [N];

    always_comb begin
        logic [REM_W-1:0]           rin;
        logic [pwi_pkg::ROOT_W-1:0] qin;
        logic [pwi_pkg::SUM_W-1:0]  sin;
        logic [REM_W+1:0]           rs;
        logic [REM_W+1:0]           trial;
        for (int j = 0; j < N; j++) begin
            if (j == 0) begin
                rin = '0;
                qin = '0;
                sin = i_sum;
            end else begin
                rin = r_rem[j-1];
                qin = r_root[j-1];
                sin = r_sum[j-1];
            end
            rs    = {rin, sin[pwi_pkg::SUM_W-1-2*j -: 2]};
            trial = {2'b00, qin, 2'b01};
            if (rs >= trial) begin
                c_rem[j]  = REM_W'(rs - trial);
                c_root[j] = {qin[pwi_pkg::ROOT_W-2:0], 1'b1};
            end else begin
                c_rem[j]  = rs[REM_W-1:0];
                c_root[j] = {qin[pwi_pkg::ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[N-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < N; j++) begin
            r_rem[j]  <= c_rem[j];
            r_root[j] <= c_root[j];
            if (j == 0) begin
                r_sum[j]  <= i_sum;
                r_mag[j]  <= i_mag;
                r_side[j] <= i_side;
            end else begin
                r_sum[j]  <= r_sum[j-1];
                r_mag[j]  <= r_mag[j-1];
                r_side[j] <= r_side[j-1];
            end
        end
    end

    assign o_valid = r_v[N-1];
    assign o_root  = r_root[N-1];
    assign o_mag   = r_mag[N-1];
    assign o_side  = r_side[N-1];

endmodule

// ===== hdl/pwi_div.sv =====
// Pipelined three-lane restoring divider that forms the Q1.30 face normal.
module pwi_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [pwi_pkg::ROOT_W-1:0] i_root,
    input  pwi_pkg::t_vec_mag          i_mag,
    input  pwi_pkg::t_side             i_side,
    output logic                       o_valid,
    output logic [2:0][31:0]           o_normal,
    output pwi_pkg::t_side             o_side
);

    localparam int N = pwi_pkg::DIV_STEPS;

    logic [pwi_pkg::DIV_STAGES-1:0] r_v;
    logic [2:0][31:0]               r_rem  [N];
    logic [2:0][N-1:0]              r_quo  [N];
    logic [31:0]                    r_root [N];
    logic [2:0]                     r_neg  [N];
    pwi_pkg::t_side                 r_side [N];
    logic [2:0][31:0]               c_rem  [N];
    logic [2:0][N-1:0]              c_quo  [N];
    logic [2:0][31:0]               r_normal;
    pwi_pkg::t_side                 r_side_out;

    always_comb begin
        logic [31:0]  rin;
        logic [N-1:0] qin;
        logic         bin;
        logic [31:0]  m;
        logic [32:0]  t;
        for (int j = 0; j < N; j++) begin
            for (int l = 0; l < 3; l++) begin
                if (j == 0) begin
                    rin = {1'b0, i_mag.babs[l][31:1]};
                    qin = '0;
                    bin = i_mag.babs[l][0];
                    m   = i_root;
                end else begin
                    rin = r_rem[j-1][l];
                    qin = r_quo[j-1][l];
                    bin = 1'b0;
                    m   = r_root[j-1];
                end
                t = {rin, bin};
                if (t >= {1'b0, m}) begin
                    c_rem[j][l] = 32'(t - {1'b0, m});
                    c_quo[j][l] = {qin[N-2:0], 1'b1};
                end else begin
                    c_rem[j][l] = t[31:0];
                    c_quo[j][l] = {qin[N-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[pwi_pkg::DIV_STAGES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < N; j++) begin
            r_rem[j] <= c_rem[j];
            r_quo[j] <= c_quo[j];
            if (j == 0) begin
                r_root[j] <= i_root;
                r_neg[j]  <= i_mag.bneg;
                r_side[j] <= i_side;
            end else begin
                r_root[j] <= r_root[j-1];
                r_neg[j]  <= r_neg[j-1];
                r_side[j] <= r_side[j-1];
            end
        end
        for (int l = 0; l < 3; l++) begin
            if (r_neg[N-1][l]) begin
                r_normal[l] <= ~{1'b0, r_quo[N-1][l]} + 32'd1;
            end else begin
                r_normal[l] <= {1'b0, r_quo[N-1][l]};
            end
        end
        r_side_out <= r_side[N-1];
    end

    assign o_valid  = r_v[pwi_pkg::DIV_STAGES-1];
    assign o_normal = r_normal;
    assign o_side   = r_side_out;

endmodule

// ===== hdl/pwi_back.sv =====
// Back stages: normal speed, projection, restitution and friction, saturation, output select.
module pwi_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [2:0][31:0]    i_normal,
    input  pwi_pkg::t_side      i_side,
    output logic                o_valid,
    output pwi_pkg::t_out_item  o_result
);

    logic [pwi_pkg::BACK_STAGES-1:0] r_v;

    logic signed [63:0] r1_prod [3];
    logic [2:0][31:0]   r1_n, r2_n;
    pwi_pkg::t_side     r1_side, r2_side, r3_side, r4_side, r5_side, r6_side;
    logic signed [33:0] r2_un;
    logic               r2_pos, r3_pos;
    logic signed [65:0] r3_raw [3];
    logic signed [34:0] r4_ut  [3];
    logic signed [51:0] r4_t2  [3];
    logic signed [51:0] r5_t1  [3];
    logic signed [51:0] r5_t2  [3];
    logic signed [53:0] r6_acc [3];
    logic signed [63:0] n_p;
    logic signed [34:0] n_ut   [3];
    logic signed [51:0] n_t2   [3];
    logic signed [53:0] n_acc  [3];
    pwi_pkg::t_out_item n_result, r_result;

    assign n_p = r1_prod[0] + r1_prod[1] + r1_prod[2];

    always_comb begin
        logic signed [33:0] pr;
        logic [16:0]        coef;
        coef = 17'd32768 + {1'b0, r3_side.e};
        for (int l = 0; l < 3; l++) begin
            pr      = $signed(r3_raw[l][63:30]);
            n_ut[l] = {{3{r3_side.u[l][31]}}, r3_side.u[l]} - {pr[33], pr};
            if (r3_pos) begin
                n_t2[l] = $signed({1'b0, coef}) * pr;
            end else begin
                n_t2[l] = '0;
            end
        end
    end

    always_comb begin
        logic signed [53:0] ux;
        for (int l = 0; l < 3; l++) begin
            ux       = {{22{r5_side.u[l][31]}}, r5_side.u[l]};
            n_acc[l] = (ux <<< 15) - {{2{r5_t1[l][51]}}, r5_t1[l]}
                       - {{2{r5_t2[l][51]}}, r5_t2[l]};
        end
    end

    always_comb begin
        logic [38:0]      v;
        logic [2:0][31:0] vs;
        logic [2:0][31:0] vo;
        for (int l = 0; l < 3; l++) begin
            v = r6_acc[l][53:15];
            if (!v[38] && (v[37:31] != '0)) begin
                vs[l] = 32'h7fff_ffff;
            end else if (v[38] && (v[37:31] != '1)) begin
                vs[l] = 32'h8000_0000;
            end else begin
                vs[l] = v[31:0];
            end
            if (r6_side.use_rebound) begin
                vo[l] = vs[l];
            end else if (r6_side.zero_vel) begin
                vo[l] = '0;
            end else begin
                vo[l] = r6_side.u[l];
            end
        end
        n_result.matched       = r6_side.matched;
        n_result.keep_particle = r6_side.keep;
        n_result.still_active  = r6_side.active;
        n_result.bad_type      = r6_side.bad;
        n_result.vel_out_x     = vo[0];
        n_result.vel_out_y     = vo[1];
        n_result.vel_out_z     = vo[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[pwi_pkg::BACK_STAGES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < 3; l++) begin
            r1_prod[l] <= $signed(i_side.u[l]) * $signed(i_normal[l]);
            r3_raw[l]  <= r2_un * $signed(r2_n[l]);
            r4_ut[l]   <= n_ut[l];
            r4_t2[l]   <= n_t2[l];
            r5_t1[l]   <= $signed({1'b0, r4_side.mu}) * r4_ut[l];
            r5_t2[l]   <= r4_t2[l];
            r6_acc[l]  <= n_acc[l];
        end
        r1_n     <= i_normal;
        r1_side  <= i_side;
        r2_un    <= $signed(n_p[63:30]);
        r2_pos   <= !n_p[63] && (n_p != '0);
        r2_n     <= r1_n;
        r2_side  <= r1_side;
        r3_pos   <= r2_pos;
        r3_side  <= r2_side;
        r4_side  <= r3_side;
        r5_side  <= r4_side;
        r6_side  <= r5_side;
        r_result <= n_result;
    end

    assign o_valid  = r_v[pwi_pkg::BACK_STAGES-1];
    assign o_result = r_result;

endmodule

// ===== hdl/particle_wall_interaction.sv =====
// Top level of the particle wall interaction pipeline with its register port.
//
//  Channel   Handshake                     Payload
//  input     start, busy (busy tied low)   i_item   (pwi_pkg::t_in_item)
//  result    o_res_valid strobe            o_result (pwi_pkg::t_out_item)
//  config    APB psel/penable/pwrite       paddr, pwdata, prdata, pready
//
// One beat is taken every clock cycle; busy never rises.
// A result leaves once its start beat has passed the front, square root, divider and back
// stages; the depth is set by the 32-stage square root and the 31-step normal divider.
// Reset clears the configuration registers and the valid bits of every stage.
// Results are shown for a single cycle and the receiver cannot stall them.
`include "particle_wall_interaction_defines.svh"

module particle_wall_interaction (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  pwi_pkg::t_in_item             i_item,
    output logic                          o_res_valid,
    output pwi_pkg::t_out_item            o_result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pwi_pkg::PADDR_W-1:0]   paddr,
    input  logic [pwi_pkg::DATA_W-1:0]    pwdata,
    output logic [pwi_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);

    logic                          r_patch_count_dummy_unused;
    logic [pwi_pkg::CNT_W-1:0]     r_patch_count;
    pwi_pkg::t_patch_entry         r_patch_entry [pwi_pkg::NUM_PATCHES];
    logic [pwi_pkg::REG_IDX_W-1:0] w_idx;
    logic                          w_write;
    logic                          w_accept;

    logic                          f_valid, s_valid, d_valid;
    logic [pwi_pkg::SUM_W-1:0]     f_sum;
    pwi_pkg::t_vec_mag             f_mag, s_mag;
    pwi_pkg::t_side                f_side, s_side, d_side;
    logic [pwi_pkg::ROOT_W-1:0]    s_root;
    logic [2:0][31:0]              d_normal;

    assign busy     = 1'b0;
    assign pready   = 1'b1;
    assign w_accept = start && !busy;
    assign w_write  = psel && penable && pwrite && pready;
    assign w_idx    = paddr[pwi_pkg::PADDR_W-1:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_patch_count_dummy_unused <= 1'b0;
        end else begin
            r_patch_count_dummy_unused <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_patch_count <= '0;
            for (int i = 0; i < pwi_pkg::NUM_PATCHES; i++) begin
                r_patch_entry[i] <= '0;
            end
        end else if (w_write) begin
            if (w_idx == pwi_pkg::REG_PATCH_COUNT) begin
                r_patch_count <= pwdata[pwi_pkg::CNT_W-1:0];
            end
            for (int i = 0; i < pwi_pkg::NUM_PATCHES; i++) begin
                if (w_idx == pwi_pkg::REG_IDX_W'(i + 1)) begin
                    r_patch_entry[i] <= pwi_pkg::t_patch_entry'(pwdata[pwi_pkg::ENTRY_W-1:0]);
                end
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (w_idx == pwi_pkg::REG_PATCH_COUNT) begin
            prdata = {{(pwi_pkg::DATA_W - pwi_pkg::CNT_W){1'b0}}, r_patch_count};
        end
        for (int i = 0; i < pwi_pkg::NUM_PATCHES; i++) begin
            if (w_idx == pwi_pkg::REG_IDX_W'(i + 1)) begin
                prdata = {{(pwi_pkg::DATA_W - pwi_pkg::ENTRY_W){1'b0}}, r_patch_entry[i]};
            end
        end
    end

    pwi_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_accept),
        .i_item        (i_item),
        .i_patch_count (r_patch_count),
        .i_patch_entry (r_patch_entry),
        .o_valid       (f_valid),
        .o_sum         (f_sum),
        .o_mag         (f_mag),
        .o_side        (f_side)
    );

    pwi_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .i_sum   (f_sum),
        .i_mag   (f_mag),
        .i_side  (f_side),
        .o_valid (s_valid),
        .o_root  (s_root),
        .o_mag   (s_mag),
        .o_side  (s_side)
    );

    pwi_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_valid),
        .i_root   (s_root),
        .i_mag    (s_mag),
        .i_side   (s_side),
        .o_valid  (d_valid),
        .o_normal (d_normal),
        .o_side   (d_side)
    );

    pwi_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (d_valid),
        .i_normal (d_normal),
        .i_side   (d_side),
        .o_valid  (o_res_valid),
        .o_result (o_result)
    );

    `PWI_ASSERT_IMP(a_latency, i_clk, i_rst_n, o_res_valid,
        $past(w_accept, pwi_pkg::LATENCY))
    `PWI_ASSERT_NXT(a_accept_tracked, i_clk, i_rst_n, w_accept, r_patch_count_dummy_unused)
    `PWI_ASSERT_IMP(a_nomatch_pass, i_clk, i_rst_n, o_res_valid && !o_result.matched,
        o_result.keep_particle && o_result.still_active && !o_result.bad_type)
    `PWI_ASSERT_IMP(a_bad_flags, i_clk, i_rst_n, o_res_valid && o_result.bad_type,
        o_result.matched && o_result.keep_particle && o_result.still_active)
    `PWI_ASSERT_IMP(a_escape_zero, i_clk, i_rst_n, o_res_valid && !o_result.keep_particle,
        !o_result.still_active && (o_result.vel_out_x == 0) && (o_result.vel_out_y == 0)
        && (o_result.vel_out_z == 0))

endmodule
